### hw/rtl/a_trous_dilated_circular_fir_row_assert.svh
// assertion macros shared by the rtl files
`ifndef A_TROUS_DILATED_CIRCULAR_FIR_ROW_ASSERT_SVH
`define A_TROUS_DILATED_CIRCULAR_FIR_ROW_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked assertion, disabled while reset is high
`define AT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// clocked assertion, checked in every cycle
`define AT_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define AT_ASSERT(lbl, ck, rs, prop, msg)
`define AT_ASSERT_NR(lbl, ck, prop, msg)
`endif

`endif

### hw/rtl/atdcf_pkg.sv
package atdcf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int TAP_W        = 16;
  localparam int OUT_W        = 20;
  localparam int OUT_TDATA_W  = 24;
  localparam int ROWLEN_W     = 11;
  localparam int SCALE_W      = 3;
  localparam int D_W          = 8;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_REG_TAPS = 4;
  localparam int FRAC_BITS    = 14;
  localparam int ROUND_BIAS   = 8192;

  localparam logic [OUT_W-1:0] OUT_MAX = 20'h7FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 20'h80000;

  // operation codes carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_SHIFT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_MODE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_ZERO     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_ONE      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_TWO      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_THREE    = 3'd6;

  typedef logic signed [TAP_W-1:0] tap_arr_t [NUM_REG_TAPS];

  // controller to datapath
  typedef struct packed {
    logic load;        // write sample, advance load position
    logic rem_start;   // start remainder pass
    logic rem_sel_d;   // remainder of dilation instead of emit position
    logic pos_direct;  // start index from emit position
    logic pos_rem;     // start index from remainder result
    logic d_direct;    // step from dilation
    logic d_rem;       // step from remainder result
    logic issue;       // read one tap sample
    logic round;       // register rounded, saturated sum
    logic push;        // move result to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic pos_wrap;
    logic d_wrap;
    logic rem_done;
    logic issue_last;
    logic mac_busy;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/atdcf_rem.sv
module atdcf_rem #(
  parameter int DIV_W = 10,
  parameter int WW    = 11,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [WW-1:0]    divisor,
  output logic             done,
  output logic [AW-1:0]    rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q;
  logic [WW-1:0]    r;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [WW:0]      trial;

  // restoring remainder, one dividend bit a cycle
  assign trial = {r, q[DIV_W-1]};
  assign rem   = r[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (running) begin
      q <= q << 1;
      if (trial >= {1'b0, divisor}) begin
        r <= WW'(trial - {1'b0, divisor});
      end else begin
        r <= trial[WW-1:0];
      end
    end
  end

endmodule

### hw/rtl/atdcf_dp.sv
`include "a_trous_dilated_circular_fir_row_assert.svh"

module atdcf_dp
  import atdcf_pkg::*;
#(
  parameter int NUM_TAPS = 4,
  parameter int ROW_MAX  = 1024,
  parameter int WW       = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [WW-1:0]              w,
  input  logic [D_W-1:0]             d,
  input  logic                       inverse,
  input  tap_arr_t                   taps,
  input  logic                       m_ready,
  output logic                       m_valid,
  output logic [OUT_W-1:0]           m_value,
  output logic                       m_last
);

  localparam int AW     = $clog2(ROW_MAX);
  localparam int KW     = $clog2(NUM_TAPS);
  localparam int DIV_W  = (AW > D_W) ? AW : D_W;
  localparam int CW     = (WW > DIV_W) ? WW : DIV_W;
  localparam int PROD_W = SAMPLE_W + TAP_W;
  localparam int ACC_W  = PROD_W + KW;
  localparam int SH_W   = ACC_W + 1 - FRAC_BITS;

  logic signed [SAMPLE_W-1:0] mem [ROW_MAX];
  logic signed [SAMPLE_W-1:0] rd_data;

  logic [WW-1:0]    load_pos;
  logic [AW-1:0]    load_addr;
  logic [AW-1:0]    emit_pos;
  logic [AW-1:0]    dmod;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    idx_next;
  logic [AW-1:0]    rem_value;
  logic [AW:0]      sum;
  logic [AW:0]      diff;
  logic [KW-1:0]    k;
  logic [KW-1:0]    tap_sel;
  logic [KW-1:0]    tap_d1;
  logic             rd_v;
  logic             prod_v;
  logic             full;
  logic             last_flag;
  logic             rem_done;
  logic [DIV_W-1:0] dividend;

  logic signed [TAP_W-1:0]  tap_mux;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W:0]           biased;
  logic [SH_W-1:0]          sh;
  logic [SH_W-OUT_W:0]      hi;
  logic                     overflow;
  logic [OUT_W-1:0]         sat;
  logic [OUT_W-1:0]         res;

  assign full      = load_pos >= w;
  assign load_addr = full ? '0 : load_pos[AW-1:0];
  assign last_flag = CW'(emit_pos) >= (CW'(w) - 1'b1);
  assign dividend  = cmd.rem_sel_d ? DIV_W'(d) : DIV_W'(emit_pos);

  assign sts.full       = full;
  assign sts.pos_wrap   = CW'(emit_pos) >= CW'(w);
  assign sts.d_wrap     = CW'(d) >= CW'(w);
  assign sts.rem_done   = rem_done;
  assign sts.issue_last = k == KW'(NUM_TAPS - 1);
  assign sts.mac_busy   = rd_v | prod_v;
  assign sts.out_free   = !m_valid || m_ready;

  atdcf_rem #(
    .DIV_W (DIV_W),
    .WW    (WW),
    .AW    (AW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rem_start),
    .dividend (dividend),
    .divisor  (w),
    .done     (rem_done),
    .rem      (rem_value)
  );

  // circular step by the reduced dilation
  always_comb begin
    sum  = (AW+1)'(idx) + (AW+1)'(dmod);
    diff = (AW+1)'(idx) - (AW+1)'(dmod);
    if (inverse) begin
      if (diff[AW]) begin
        idx_next = AW'(diff + (AW+1)'(w));
      end else begin
        idx_next = diff[AW-1:0];
      end
    end else begin
      if (sum >= (AW+1)'(w)) begin
        idx_next = AW'(sum - (AW+1)'(w));
      end else begin
        idx_next = sum[AW-1:0];
      end
    end
  end

  // forward walks the taps from the last one down
  assign tap_sel = inverse ? k : (KW'(NUM_TAPS - 1) - k);

  // taps past the register set read as zero
  always_comb begin
    tap_mux = '0;
    for (int j = 0; j < NUM_REG_TAPS; j++) begin
      if (j < NUM_TAPS && tap_d1 == KW'(j)) begin
        tap_mux = taps[j];
      end
    end
  end

  // round half up, then saturate
  always_comb begin
    biased   = {acc[ACC_W-1], acc} + (ACC_W+1)'(ROUND_BIAS);
    sh       = biased[ACC_W:FRAC_BITS];
    hi       = sh[SH_W-1:OUT_W-1];
    overflow = (|hi) && !(&hi);
    if (overflow) begin
      sat = sh[SH_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      sat = sh[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[load_addr] <= sample;
    end
    if (cmd.issue) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      emit_pos <= '0;
      rd_v     <= 1'b0;
      prod_v   <= 1'b0;
      k        <= '0;
      m_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          load_pos <= WW'(1);
          emit_pos <= '0;
        end else begin
          load_pos <= load_pos + 1'b1;
        end
      end
      if (cmd.push) begin
        if (last_flag) begin
          load_pos <= '0;
          emit_pos <= '0;
        end else begin
          emit_pos <= emit_pos + 1'b1;
        end
      end
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
      if (cmd.pos_direct || cmd.pos_rem) begin
        k <= '0;
      end else if (cmd.issue) begin
        k <= k + 1'b1;
      end
      if (cmd.push) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_direct) begin
      idx <= emit_pos;
      acc <= '0;
    end else if (cmd.pos_rem) begin
      idx <= rem_value;
      acc <= '0;
    end else begin
      if (cmd.issue) begin
        idx <= idx_next;
      end
      if (prod_v) begin
        acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
    if (cmd.d_direct) begin
      dmod <= AW'(d);
    end else if (cmd.d_rem) begin
      dmod <= rem_value;
    end
    if (cmd.issue) begin
      tap_d1 <= tap_sel;
    end
    if (rd_v) begin
      prod <= rd_data * tap_mux;
    end
    if (cmd.round) begin
      res <= sat;
    end
    if (cmd.push) begin
      m_value <= res;
      m_last  <= last_flag;
    end
  end

  `AT_ASSERT(a_push_drained, clk, rst, cmd.push |-> !rd_v && !prod_v, "result pushed with products in flight")
  `AT_ASSERT(a_idx_in_row, clk, rst, cmd.issue |-> CW'(idx) < CW'(w), "tap read outside the row")
  `AT_ASSERT(a_load_bound, clk, rst, cmd.load |=> CW'(load_pos) <= CW'(ROW_MAX), "load position past buffer")

endmodule

### hw/rtl/atdcf_ctrl.sv
module atdcf_ctrl
  import atdcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_valid,
  input  logic op,
  output logic s_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RPOS  = 6'b000010,
    S_RD    = 6'b000100,
    S_TAPS  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          if (op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.full) begin
            if (sts.pos_wrap) begin
              cmd.rem_start = 1'b1;
              state_next    = S_RPOS;
            end else begin
              cmd.pos_direct = 1'b1;
              if (sts.d_wrap) begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel_d = 1'b1;
                state_next    = S_RD;
              end else begin
                cmd.d_direct = 1'b1;
                state_next   = S_TAPS;
              end
            end
          end
        end
      end
      S_RPOS: begin
        if (sts.rem_done) begin
          cmd.pos_rem = 1'b1;
          if (sts.d_wrap) begin
            cmd.rem_start = 1'b1;
            cmd.rem_sel_d = 1'b1;
            state_next    = S_RD;
          end else begin
            cmd.d_direct = 1'b1;
            state_next   = S_TAPS;
          end
        end
      end
      S_RD: begin
        if (sts.rem_done) begin
          cmd.d_rem  = 1'b1;
          state_next = S_TAPS;
        end
      end
      S_TAPS: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.mac_busy) begin
          cmd.round  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/a_trous_dilated_circular_fir_row.sv
// load word: written to the line buffer on accept; emit word: result formed by one
// line-memory read per tap plus mac drain, pushed once the output register is free;
// no new word is accepted until then; a remainder pass is added for each of emit
// position not below the row length and dilation not below the row length
// synchronous active-high reset: positions zero, row_length 1024, other registers zero,
// line buffer contents undefined until loaded
module a_trous_dilated_circular_fir_row
  import atdcf_pkg::*;
#(
  parameter int NUM_TAPS = 4,
  parameter int ROW_MAX  = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
  input  logic                   s_tuser,   // [0] operation
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [19:0] filtered_value, [23:20] zero
  output logic                   m_tlast,   // last_output
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW = $clog2(ROW_MAX + 1);
  localparam int CW = (WW > ROWLEN_W) ? WW : ROWLEN_W;

  logic [ROWLEN_W-1:0] row_length;
  logic [SCALE_W-1:0]  scale_shift;
  logic                inverse_mode;
  tap_arr_t            taps;

  logic [CW-1:0]    rl_ext;
  logic [WW-1:0]    w;
  logic [D_W-1:0]   d;
  logic [OUT_W-1:0] m_value;
  cmd_t             cmd;
  sts_t             sts;

  // registers always take a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= ROWLEN_W'(1024);
      scale_shift  <= '0;
      inverse_mode <= 1'b0;
      for (int j = 0; j < NUM_REG_TAPS; j++) begin
        taps[j] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_LENGTH:   row_length   <= cfg_data[ROWLEN_W-1:0];
        REG_SCALE_SHIFT:  scale_shift  <= cfg_data[SCALE_W-1:0];
        REG_INVERSE_MODE: inverse_mode <= cfg_data[0];
        REG_TAP_ZERO:     taps[0]      <= cfg_data;
        REG_TAP_ONE:      taps[1]      <= cfg_data;
        REG_TAP_TWO:      taps[2]      <= cfg_data;
        REG_TAP_THREE:    taps[3]      <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // effective row length clamped to one .. ROW_MAX
  assign rl_ext = CW'(row_length);
  always_comb begin
    if (rl_ext == '0) begin
      w = WW'(1);
    end else if (rl_ext > CW'(ROW_MAX)) begin
      w = WW'(ROW_MAX);
    end else begin
      w = WW'(rl_ext);
    end
  end

  // tap spacing, up to 128 samples
  assign d = D_W'(1) << scale_shift;

  atdcf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .op      (s_tuser),
    .s_ready (s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  atdcf_dp #(
    .NUM_TAPS (NUM_TAPS),
    .ROW_MAX  (ROW_MAX),
    .WW       (WW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .sample  (s_tdata),
    .w       (w),
    .d       (d),
    .inverse (inverse_mode),
    .taps    (taps),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .m_value (m_value),
    .m_last  (m_tlast)
  );

  assign m_tdata = {(OUT_TDATA_W-OUT_W)'(0), m_value};

endmodule
